/* hw/rtl/drr_pkg.sv */
// drr_pkg: types and constants shared by the direct-to-reverberant ratio block
// no dependencies; imported by the front, back, queue and top level
package drr_pkg;

   localparam int EnergyBits = 64;
   localparam int PosBits    = 20;
   localparam int CountBits  = 21;
   localparam int HalfBits   = 10;
   localparam int FracBits   = 24;
   localparam int IntBits    = 6;
   localparam int LogBits    = IntBits + FracBits;
   localparam int DrrBits    = 16;
   localparam int PeakAtBits = 12;

   // 10*log10(2) in Q30
   localparam logic [31:0] DbPerLog2Q30 = 32'd3232284966;
   localparam logic [HalfBits-1:0] HalfReset = 10'd120;

   // one finished recording handed from the front to the back
   typedef struct packed {
      logic [PosBits-1:0]    peak_pos;
      logic [CountBits-1:0]  count;
      logic [EnergyBits-1:0] total;
      logic [HalfBits-1:0]   half;
      logic                  overflow;
      logic                  silent;
   } job_type;

   typedef enum logic [1:0] {
      F_LOAD,
      F_FLUSH,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_WALK,
      B_NORM,
      B_FRAC,
      B_MUL,
      B_OUT
   } back_state_type;

endpackage

/* hw/rtl/drr_ram.sv */
// drr_ram: generic single write port, single read port ram with registered read
// no dependencies
module drr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/drr_queue.sv */
// drr_queue: two-entry queue of recording jobs between front and back
// depends on drr_pkg
module drr_queue import drr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type pop_job,
   output logic    empty
);

   job_type    entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign pop_job = entries_ff[rd_ptr_ff];
   assign full    = count_ff == 2'd2;
   assign empty   = count_ff == 2'd0;

endmodule

/* hw/rtl/drr_front.sv */
// drr_front: takes samples, stores them, tracks peak and total energy
// depends on drr_pkg; writes the sample ram and pushes jobs to drr_queue
module drr_front import drr_pkg::*; #(
   parameter int MAX_SAMPLES = 4096,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_BITS-1:0]  req_sample,
   input  logic                           req_last,
   input  logic [HalfBits-1:0]            window_half,
   input  logic                           ram_busy,
   output logic                           ram_wr_en,
   output logic [$clog2(MAX_SAMPLES)-1:0] ram_wr_addr,
   output logic [SAMPLE_BITS-1:0]         ram_wr_data,
   output logic                           push,
   output job_type                        push_job,
   input  logic                           queue_full
);

   localparam int AW = $clog2(MAX_SAMPLES);
   localparam int SB = SAMPLE_BITS;

   front_state_type state_ff, state_in;
   logic [AW:0]           count_ff, count_in;
   logic [SB-1:0]         peak_mag_ff, peak_mag_in;
   logic [AW-1:0]         peak_pos_ff, peak_pos_in;
   logic [EnergyBits-1:0] total_ff, total_in;
   logic                  overflow_ff, overflow_in;
   logic                  mag_vld_ff, sq_vld_ff;
   logic [SB-1:0]         mag_ff;
   logic [2*SB-1:0]       sq_ff;

   logic                  accept, has_room, store;
   logic [SB-1:0]         mag;
   logic [EnergyBits:0]   sum;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_LOAD: begin
            if (accept && req_last) state_in = F_FLUSH;
         end
         F_FLUSH: begin
            if (!mag_vld_ff && !sq_vld_ff) state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!queue_full) state_in = F_LOAD;
         end
         default: state_in = F_LOAD;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      push      = 1'b0;
      case (state_ff)
         F_LOAD:  req_ready = !ram_busy;
         F_FLUSH: req_ready = 1'b0;
         F_PUSH:  push = !queue_full;
         default: req_ready = 1'b0;
      endcase
   end

   always_comb begin
      accept   = req_valid && req_ready;
      has_room = count_ff != (AW+1)'(MAX_SAMPLES);
      store    = accept && has_room;
      mag      = req_sample[SB-1] ? (~req_sample + 1'b1) : req_sample;
      sum      = {1'b0, total_ff} + (EnergyBits+1)'(sq_ff & {(2*SB){sq_vld_ff}});
      total_in    = sum[EnergyBits] ? '1 : sum[EnergyBits-1:0];
      count_in    = count_ff + (AW+1)'(store);
      overflow_in = overflow_ff | (accept && !has_room);
      peak_mag_in = peak_mag_ff;
      peak_pos_in = peak_pos_ff;
      if (store && mag > peak_mag_ff) begin
         peak_mag_in = mag;
         peak_pos_in = count_ff[AW-1:0];
      end
      if (push) begin
         count_in    = '0;
         total_in    = '0;
         overflow_in = 1'b0;
         peak_mag_in = '0;
         peak_pos_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= F_LOAD;
         count_ff    <= '0;
         peak_mag_ff <= '0;
         peak_pos_ff <= '0;
         total_ff    <= '0;
         overflow_ff <= 1'b0;
         mag_vld_ff  <= 1'b0;
         sq_vld_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         peak_mag_ff <= peak_mag_in;
         peak_pos_ff <= peak_pos_in;
         total_ff    <= total_in;
         overflow_ff <= overflow_in;
         mag_vld_ff  <= store;
         sq_vld_ff   <= mag_vld_ff;
      end
   end

   // square is registered before it is accumulated
   always_ff @(posedge clock) begin
      mag_ff <= mag;
      sq_ff  <= (2*SB)'(mag_ff) * (2*SB)'(mag_ff);
   end

   assign ram_wr_en   = store;
   assign ram_wr_addr = count_ff[AW-1:0];
   assign ram_wr_data = req_sample;

   always_comb begin
      push_job.peak_pos = PosBits'(peak_pos_ff);
      push_job.count    = CountBits'(count_ff);
      push_job.total    = total_ff;
      push_job.half     = (window_half == '0) ? HalfBits'(1) : window_half;
      push_job.overflow = overflow_ff;
      push_job.silent   = peak_mag_ff == '0;
   end

endmodule

/* hw/rtl/drr_back.sv */
// drr_back: sums direct window energy, takes both log2 values and the dB ratio
// depends on drr_pkg; reads the sample ram and pops jobs from drr_queue
module drr_back import drr_pkg::*; #(
   parameter int MAX_SAMPLES = 4096,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   output logic                           pop,
   input  job_type                        pop_job,
   input  logic                           queue_empty,
   output logic [$clog2(MAX_SAMPLES)-1:0] ram_rd_addr,
   input  logic [SAMPLE_BITS-1:0]         ram_rd_data,
   output logic                           ram_busy,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [DrrBits-1:0]      rsp_drr_q8,
   output logic                           rsp_silent,
   output logic                           rsp_truncated,
   output logic [PeakAtBits-1:0]          rsp_peak_at
);

   localparam int AW = $clog2(MAX_SAMPLES);
   localparam int SB = SAMPLE_BITS;
   localparam int WB = CountBits + 1;

   back_state_type state_ff, state_in;
   job_type               job_ff;
   logic [AW:0]           addr_ff, hi_ff;
   logic                  rd_vld_ff, sq_vld_ff;
   logic [2*SB-1:0]       sq_ff;
   logic [EnergyBits-1:0] direct_ff, direct_in;
   logic [EnergyBits-1:0] x_ff;
   logic [IntBits-1:0]    p_ff;
   logic [31:0]           m_ff;
   logic [FracBits-1:0]   frac_ff;
   logic [4:0]            step_ff;
   logic                  phase_ff;
   logic [LogBits-1:0]    ld_ff, dmag_ff;
   logic                  neg_ff;
   logic [61:0]           prod_ff;
   logic                  rsp_valid_ff, rsp_silent_ff, rsp_trunc_ff;
   logic [DrrBits-1:0]    rsp_drr_ff;
   logic [PeakAtBits-1:0] rsp_peak_ff;

   logic                  issue, walk_done, frac_done, out_free, out_load;
   logic [WB-1:0]         pos_w, half_w, lo_w, hi_w, cnt_w;
   logic [SB-1:0]         rd_mag;
   logic [EnergyBits:0]   dsum;
   logic [EnergyBits-1:0] reverb, direct_nz;
   logic [63:0]           msq;
   logic [32:0]           mt;
   logic [FracBits-1:0]   frac_new;
   logic [LogBits-1:0]    lr;
   logic [61:0]           rnd;
   logic [16:0]           q;
   logic [DrrBits-1:0]    drr;

   // direct window clipped to the recording
   always_comb begin
      pos_w  = WB'(pop_job.peak_pos);
      half_w = WB'(pop_job.half);
      cnt_w  = WB'(pop_job.count);
      lo_w   = (pos_w > half_w) ? pos_w - half_w : '0;
      hi_w   = pos_w + half_w + WB'(1);
      if (hi_w > cnt_w) hi_w = cnt_w;
   end

   always_comb begin
      issue     = (state_ff == B_WALK) && (addr_ff < hi_ff);
      walk_done = (state_ff == B_WALK) && !issue && !rd_vld_ff && !sq_vld_ff;
      frac_done = step_ff == 5'(FracBits - 1);
      out_free  = !rsp_valid_ff || rsp_ready;
      rd_mag    = ram_rd_data[SB-1] ? (~ram_rd_data + 1'b1) : ram_rd_data;
      dsum      = {1'b0, direct_ff} + (EnergyBits+1)'(sq_ff & {(2*SB){sq_vld_ff}});
      direct_in = dsum[EnergyBits] ? '1 : dsum[EnergyBits-1:0];
      direct_nz = (direct_ff == '0) ? EnergyBits'(1) : direct_ff;
      reverb    = job_ff.total - direct_ff;
      if (reverb == '0) reverb = EnergyBits'(1);
      msq       = 64'(m_ff) * 64'(m_ff);
      mt        = msq[63:31];
      frac_new  = {frac_ff[FracBits-2:0], mt[32]};
      lr        = {p_ff, frac_new};
      rnd       = prod_ff + (62'(1) << 45);
      q         = rnd[61:45] >> 1;
      if (neg_ff) begin
         drr = (q > 17'd32768) ? 16'h8000 : 16'(-q);
      end else begin
         drr = (q > 17'd32767) ? 16'h7fff : q[15:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (!queue_empty) state_in = pop_job.silent ? B_OUT : B_WALK;
         end
         B_WALK: begin
            if (walk_done) state_in = B_NORM;
         end
         B_NORM: begin
            if (x_ff[EnergyBits-1]) state_in = B_FRAC;
         end
         B_FRAC: begin
            if (frac_done) state_in = phase_ff ? B_MUL : B_NORM;
         end
         B_MUL:   state_in = B_OUT;
         B_OUT: begin
            if (out_free) state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop      = 1'b0;
      out_load = 1'b0;
      ram_busy = 1'b0;
      case (state_ff)
         B_IDLE:  pop = !queue_empty;
         B_WALK:  ram_busy = 1'b1;
         B_OUT:   out_load = out_free;
         default: pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rd_vld_ff    <= 1'b0;
         sq_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= issue;
         sq_vld_ff <= rd_vld_ff;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      sq_ff <= (2*SB)'(rd_mag) * (2*SB)'(rd_mag);
      case (state_ff)
         B_IDLE: begin
            job_ff    <= pop_job;
            addr_ff   <= (AW+1)'(lo_w);
            hi_ff     <= (AW+1)'(hi_w);
            direct_ff <= '0;
            phase_ff  <= 1'b0;
         end
         B_WALK: begin
            direct_ff <= direct_in;
            if (issue) addr_ff <= addr_ff + 1'b1;
            x_ff <= direct_nz;
            p_ff <= '1;
         end
         B_NORM: begin
            // leading one search, one bit a cycle
            if (x_ff[EnergyBits-1]) begin
               m_ff    <= x_ff[EnergyBits-1 -: 32];
               frac_ff <= '0;
               step_ff <= '0;
            end else begin
               x_ff <= x_ff << 1;
               p_ff <= p_ff - 1'b1;
            end
         end
         B_FRAC: begin
            frac_ff <= frac_new;
            step_ff <= step_ff + 1'b1;
            m_ff    <= mt[32] ? mt[32:1] : mt[31:0];
            if (frac_done) begin
               ld_ff    <= lr;
               phase_ff <= 1'b1;
               x_ff     <= reverb;
               p_ff     <= '1;
               neg_ff   <= lr > ld_ff;
               dmag_ff  <= (lr > ld_ff) ? lr - ld_ff : ld_ff - lr;
            end
         end
         B_MUL: begin
            prod_ff <= 62'(dmag_ff) * 62'(DbPerLog2Q30);
         end
         B_OUT: begin
            if (out_load) begin
               rsp_drr_ff    <= job_ff.silent ? '0 : drr;
               rsp_silent_ff <= job_ff.silent;
               rsp_trunc_ff  <= job_ff.overflow;
               rsp_peak_ff   <= job_ff.silent ? '0 : PeakAtBits'(job_ff.peak_pos);
            end
         end
         default: ;
      endcase
   end

   assign ram_rd_addr   = addr_ff[AW-1:0];
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drr_q8    = rsp_drr_ff;
   assign rsp_silent    = rsp_silent_ff;
   assign rsp_truncated = rsp_trunc_ff;
   assign rsp_peak_at   = rsp_peak_ff;

endmodule

/* hw/rtl/direct_to_reverberant_ratio.sv */
// direct_to_reverberant_ratio: one sample a cycle while a recording loads, unless
// the sample ram is busy. after the last sample: flush, window walk through the
// sample ram, the direct and the reverberant log in the shared log2 unit, then
// scaling; a 64 entry leading-one search bounds the log.
// synchronous active-high reset clears all control state; window_half -> 120.
module direct_to_reverberant_ratio import drr_pkg::*; #(
   parameter int MAX_SAMPLES = 4096,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [DrrBits-1:0]     rsp_drr_q8,
   output logic                          rsp_silent,
   output logic                          rsp_truncated,
   output logic [PeakAtBits-1:0]         rsp_peak_at,
   input  logic                          csr_wr_en,
   input  logic [HalfBits-1:0]           csr_wr_data
);

   localparam int AW = $clog2(MAX_SAMPLES);

   logic [HalfBits-1:0]    window_half_ff;
   logic                   ram_wr_en, back_busy, ram_busy;
   logic [AW-1:0]          ram_wr_addr, ram_rd_addr;
   logic [SAMPLE_BITS-1:0] ram_wr_data, ram_rd_data;
   logic                   push, pop, queue_full, queue_empty;
   job_type                push_job, pop_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_half_ff <= HalfReset;
      end else if (csr_wr_en) begin
         window_half_ff <= csr_wr_data;
      end
   end

   // the ram holds one recording until its window walk is done
   assign ram_busy = back_busy || !queue_empty;

   drr_front #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_sample, .req_last,
      .window_half(window_half_ff), .ram_busy,
      .ram_wr_en, .ram_wr_addr, .ram_wr_data,
      .push, .push_job, .queue_full
   );

   drr_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_ram (
      .clock, .wr_en(ram_wr_en), .wr_addr(ram_wr_addr), .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr), .rd_data(ram_rd_data)
   );

   drr_queue u_queue (
      .clock, .reset, .push, .push_job, .full(queue_full),
      .pop, .pop_job, .empty(queue_empty)
   );

   drr_back #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
      .clock, .reset, .pop, .pop_job, .queue_empty,
      .ram_rd_addr, .ram_rd_data, .ram_busy(back_busy),
      .rsp_valid, .rsp_ready, .rsp_drr_q8, .rsp_silent, .rsp_truncated, .rsp_peak_at
   );

endmodule

/* hw/rtl/drr_checker.sv */
// drr_port_checks: port-level checks on the direct-to-reverberant ratio block
// depends on drr_pkg; bound to direct_to_reverberant_ratio
module drr_port_checks import drr_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      req_last,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [DrrBits-1:0] rsp_drr_q8,
   input logic                      rsp_silent,
   input logic [PeakAtBits-1:0]     rsp_peak_at
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drr_q8) && $stable(rsp_peak_at))
      else $error("result changed while stalled");

   a_silent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_silent |-> rsp_drr_q8 == '0 && rsp_peak_at == '0)
      else $error("silent result with nonzero ratio or peak");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_last_flush: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready)
      else $error("item taken right after end of recording");

endmodule

bind direct_to_reverberant_ratio drr_port_checks u_drr_port_checks (
   .clock, .reset, .req_valid, .req_ready, .req_last,
   .rsp_valid, .rsp_ready, .rsp_drr_q8, .rsp_silent, .rsp_peak_at
);

/* tb/sv/drr_checker.sv */
// drr_checker: watches the sample and ratio channels of direct_to_reverberant_ratio,
// predicts each ratio from the accepted samples and compares field by field
// depends on drr_pkg for widths and the scale constant
module drr_checker import drr_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic signed [23:0]        req_sample,
   input  logic                      req_last,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic signed [DrrBits-1:0] rsp_drr_q8,
   input  logic                      rsp_silent,
   input  logic                      rsp_truncated,
   input  logic [PeakAtBits-1:0]     rsp_peak_at,
   input  logic                      csr_wr_en,
   input  logic [HalfBits-1:0]       csr_wr_data,
   output int                        failures,
   output int                        pending,
   output int                        samples_seen,
   output int                        ratios_seen,
   output int                        silent_seen,
   output int                        truncated_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Depth = 4096;

   typedef struct {
      logic signed [DrrBits-1:0] drr;
      logic                      silent;
      logic                      truncated;
      logic [PeakAtBits-1:0]     peak_at;
   } ratio_type;

   ratio_type expected_ratios[$];

   logic signed [23:0] recording[Depth];
   logic [23:0]        peak_mag;
   int                 peak_idx;
   int                 held;
   logic [63:0]        energy;
   logic               overflowed;
   logic [HalfBits-1:0] window_half;

   task automatic report(input string field, input int got, input int want);
      $display("mismatch on %s at %0t: got %0d, expected %0d", field, $time, got, want);
      failures++;
   endtask

   function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   // integer part is the leading-one index, fraction by repeated squaring
   function automatic logic [LogBits-1:0] log2_q24(input logic [63:0] x);
      int          p;
      logic [63:0] m;
      logic [FracBits-1:0] frac;
      p = 0;
      for (int i = 0; i < 64; i++)
         if (x[i]) p = i;
      m = (p >= 31) ? (x >> (p - 31)) : (x << (31 - p));
      frac = '0;
      repeat (FracBits) begin
         m = (m * m) >> 31;
         frac = {frac[FracBits-2:0], (m >= 64'h1_0000_0000)};
         if (m >= 64'h1_0000_0000) m = m >> 1;
      end
      return {p[IntBits-1:0], frac};
   endfunction

   function automatic logic signed [DrrBits-1:0] db_ratio(input logic [63:0] direct,
                                                         input logic [63:0] reverb);
      logic [LogBits-1:0] ld, lr, mag;
      logic               neg;
      logic [63:0]        q;
      ld = log2_q24(direct);
      lr = log2_q24(reverb);
      neg = lr > ld;
      mag = neg ? lr - ld : ld - lr;
      q = ({34'd0, mag} * {32'd0, DbPerLog2Q30} + (64'd1 << 45)) >> 46;
      if (neg) return (q > 32768) ? -16'sd32768 : -$signed(q[15:0]);
      return (q > 32767) ? 16'sd32767 : $signed(q[15:0]);
   endfunction

   function automatic ratio_type finish_recording();
      ratio_type   r;
      int          half, lo, hi;
      logic [63:0] direct, reverb;
      logic [23:0] a;
      r.truncated = overflowed;
      if (peak_mag == 0) begin
         r.drr = '0;
         r.silent = 1'b1;
         r.peak_at = '0;
         return r;
      end
      half = (window_half == 0) ? 1 : window_half;
      lo = (peak_idx > half) ? peak_idx - half : 0;
      hi = peak_idx + half + 1;
      if (hi > held) hi = held;
      direct = '0;
      for (int i = lo; i < hi; i++) begin
         a = recording[i] < 0 ? -recording[i] : recording[i];
         direct = sat_sum(direct, 64'(a) * 64'(a));
      end
      reverb = energy - direct;
      if (direct == 0) direct = 1;
      if (reverb == 0) reverb = 1;
      r.drr = db_ratio(direct, reverb);
      r.silent = 1'b0;
      r.peak_at = peak_idx[PeakAtBits-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      ratio_type   want;
      logic [23:0] a;
      if (reset) begin
         window_half = HalfReset;
         peak_mag = '0;
         peak_idx = 0;
         held = 0;
         energy = '0;
         overflowed = 1'b0;
         expected_ratios.delete();
      end else begin
         if (csr_wr_en) window_half = csr_wr_data;
         if (req_valid && req_ready) begin
            samples_seen++;
            a = req_sample < 0 ? -req_sample : req_sample;
            if (held < Depth) begin
               recording[held] = req_sample;
               if (a > peak_mag) begin
                  peak_mag = a;
                  peak_idx = held;
               end
               energy = sat_sum(energy, 64'(a) * 64'(a));
               held++;
            end else begin
               overflowed = 1'b1;
            end
            if (req_last) begin
               expected_ratios.push_back(finish_recording());
               peak_mag = '0;
               peak_idx = 0;
               held = 0;
               energy = '0;
               overflowed = 1'b0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            ratios_seen++;
            if (rsp_silent) silent_seen++;
            if (rsp_truncated) truncated_seen++;
            if (expected_ratios.size() == 0) begin
               report("unexpected ratio count", ratios_seen, ratios_seen - 1);
            end else begin
               want = expected_ratios.pop_front();
               if (rsp_drr_q8 !== want.drr) report("drr_q8", rsp_drr_q8, want.drr);
               if (rsp_silent !== want.silent) report("silent", rsp_silent, want.silent);
               if (rsp_truncated !== want.truncated)
                  report("truncated", rsp_truncated, want.truncated);
               if (rsp_peak_at !== want.peak_at) report("peak_at", rsp_peak_at, want.peak_at);
            end
         end
      end
      pending = expected_ratios.size();
   end

   initial begin
      failures = 0;
      pending = 0;
      samples_seen = 0;
      ratios_seen = 0;
      silent_seen = 0;
      truncated_seen = 0;
   end

endmodule

/* tb/sv/testbench.sv */
// testbench: drives recordings and window settings into direct_to_reverberant_ratio
// and gives the verdict; depends on drr_pkg and drr_checker
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import drr_pkg::*;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic signed [23:0]        req_sample;
   logic                      req_last;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [DrrBits-1:0] rsp_drr_q8;
   logic                      rsp_silent;
   logic                      rsp_truncated;
   logic [PeakAtBits-1:0]     rsp_peak_at;
   logic                      csr_wr_en;
   logic [HalfBits-1:0]       csr_wr_data;

   int failures, pending, samples_seen, ratios_seen, silent_seen, truncated_seen;
   int items_sent;
   bit calm;

   direct_to_reverberant_ratio #(.MAX_SAMPLES(4096), .SAMPLE_BITS(24)) dut (.*);

   drr_checker u_checker (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(negedge clock)
      rsp_ready <= calm || ($urandom_range(99) >= 14);

   initial begin
      #40ms;
      $display("[direct_to_reverberant_ratio] ERROR");
      $finish;
   end

   // one item; valid holds until accepted
   task automatic send(input logic signed [23:0] value, input logic last);
      while (!calm && $urandom_range(99) < 14) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_sample = value;
      req_last = last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      items_sent++;
   endtask

   // walk for a window half of up to 1023 plus log and flush, with margin
   task automatic drain();
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (2600) @(negedge clock);
   endtask

   task automatic set_window(input logic [HalfBits-1:0] value);
      drain();
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   function automatic logic signed [23:0] pick(input int kind);
      case (kind)
         0: return '0;
         1: return $signed(24'($urandom_range(7))) - 24'sd3;
         2: return $signed(24'($urandom));
         default: return $signed(24'($urandom_range(4095))) - 24'sd2048;
      endcase
   endfunction

   task automatic recording(input int len, input int kind);
      int peak_spot;
      peak_spot = $urandom_range(len - 1);
      for (int i = 0; i < len; i++) begin
         if (kind == 3 && i == peak_spot)
            send($urandom_range(1) ? 24'sh7FFFFF : -24'sh800000 + 24'($urandom_range(1)),
                 i == len - 1);
         else
            send(pick(kind), i == len - 1);
      end
   endtask

   initial begin
      int len;
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample = '0;
      req_last = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      rsp_ready = 1'b0;
      calm = 1'b0;
      items_sent = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, silence, ties, reverb-free and truncated recordings
      send(24'sh7FFFFF, 1'b1);
      send(-24'sh800000, 1'b1);
      send(24'sh0, 1'b1);
      send(24'sh0, 1'b0);
      send(24'sh0, 1'b0);
      send(24'sh0, 1'b1);
      send(24'sh3, 1'b0);
      send(-24'sh3, 1'b0);
      send(24'sh3, 1'b1);
      send(24'sh1, 1'b0);
      send(-24'sh800000, 1'b0);
      send(24'sh7FFFFF, 1'b0);
      send(24'sh2, 1'b1);
      set_window(10'd0);
      send(24'sh10, 1'b0);
      send(24'sh100, 1'b0);
      send(24'sh10, 1'b0);
      send(24'sh7, 1'b1);
      set_window(10'd1);
      send(24'sh5, 1'b0);
      send(-24'sh7FFFFF, 1'b0);
      send(24'sh5, 1'b0);
      send(24'sh1, 1'b1);
      // store full: the last marker lands on an ignored sample
      for (int i = 0; i < 4099; i++) send(i == 4000 ? 24'sh400 : pick(1), i == 4098);
      set_window(10'd1023);
      for (int i = 0; i < 2100; i++) send(i == 1500 ? -24'sh123456 : pick(3), i == 2099);

      // random recordings, window changed between phases
      items_sent = 0;
      while (items_sent < 1500) begin
         if ($urandom_range(9) == 0) set_window(10'($urandom_range(1023)));
         calm = (items_sent > 600 && items_sent < 850);
         len = ($urandom_range(39) == 0) ? $urandom_range(100, 600) : $urandom_range(1, 24);
         recording(len, $urandom_range(5));
      end
      calm = 1'b0;
      set_window(10'd120);
      recording(5, 2);
      drain();

      $display("%0d samples in, %0d ratios out, %0d silent and %0d truncated",
               samples_seen, ratios_seen, silent_seen, truncated_seen);
      $display("window settings covered 0, 1, 1023, 120 and random values");
      if (failures == 0) begin
         $display("[direct_to_reverberant_ratio] OK");
      end else begin
         $display("[direct_to_reverberant_ratio] ERROR");
      end
      $finish;
   end

endmodule

/* direct_to_reverberant_ratio.f */
hw/rtl/drr_pkg.sv
hw/rtl/drr_ram.sv
hw/rtl/drr_queue.sv
hw/rtl/drr_front.sv
hw/rtl/drr_back.sv
hw/rtl/direct_to_reverberant_ratio.sv
hw/rtl/drr_checker.sv
tb/sv/drr_checker.sv
tb/sv/testbench.sv
